/* rtl/pep_pkg.sv */
package pep_pkg;

  // fixed point layout
  localparam int FRAC_BITS = 16;
  localparam int COL_W     = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;

  // projection divider: quotient bits needed below the cap of 2^33
  localparam int QUOT_W = 34;
  localparam int QPER   = 2;
  localparam int QSTG   = QUOT_W / QPER;
  localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(64'd1 << 33);

  // slope divider: 33-bit magnitude over a 16-bit span
  localparam int SMAG_W = 33;
  localparam int SPER   = 3;
  localparam int SSTG   = SMAG_W / SPER;
  localparam int SPAN_W = 16;

  localparam logic [DATA_W-1:0] FOCAL_RESET  = 32'd16777216;
  localparam logic [DATA_W-1:0] CENTER_RESET = 32'd0;
  localparam logic [DATA_W-1:0] EYE_RESET    = 32'd0;

  typedef enum logic [1:0] {
    CFG_FOCAL_SCALE     = 2'd0,
    CFG_SCREEN_CENTER_Y = 2'd1,
    CFG_EYE_HEIGHT      = 2'd2
  } pep_cfg_idx_t;

  // sideband that travels beside the projection dividers
  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  lc;
    logic [COL_W-1:0]  rc;
    logic              negc;
    logic              negf;
    logic              span_pos;
    logic [SPAN_W-1:0] span;
  } pep_qside_t;

  // sideband that travels beside the slope dividers
  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  lc;
    logic [COL_W-1:0]  rc;
    logic [DATA_W-1:0] cyl;
    logic [DATA_W-1:0] cyr;
    logic [DATA_W-1:0] fyl;
    logic [DATA_W-1:0] fyr;
    logic [COL_W-1:0]  crl;
    logic [COL_W-1:0]  crr;
    logic [COL_W-1:0]  frl;
    logic [COL_W-1:0]  frr;
    logic              negc;
    logic              negf;
    logic              span_pos;
  } pep_sside_t;

  function automatic logic [DATA_W-1:0] sat_s32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [COL_W-1:0] sat_s16(input logic signed [32:0] v);
    if (v > 33'sd32767) begin
      return 16'h7fff;
    end else if (v < -33'sd32768) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

/* rtl/pep_qdiv.sv */
module pep_qdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pep_pkg::PROD_W-1:0]    prod_i,
  input  logic [pep_pkg::DATA_W-1:0]    depth_i,
  output logic [pep_pkg::QUOT_W-1:0]    q_o,
  output logic                          cap_o,
  output logic                          zero_o
);

  localparam int QW = pep_pkg::QUOT_W;
  localparam int DW = pep_pkg::DATA_W;
  localparam int NS = pep_pkg::QSTG;

  logic [DW-1:0] rem_r [0:NS];
  logic [QW-1:0] dvd_r [0:NS];
  logic [QW-1:0] quo_r [0:NS];
  logic [DW-1:0] dep_r [0:NS];
  logic          cap_r [0:NS];
  logic          zero_r[0:NS];

  logic [DW-1:0] rem_nxt [1:NS];
  logic [QW-1:0] dvd_nxt [1:NS];
  logic [QW-1:0] quo_nxt [1:NS];

  // high part at or above the depth means the quotient is past the cap
  logic [DW-1:0] hi_w;
  assign hi_w = DW'(prod_i[pep_pkg::PROD_W-1:QW]);

  always_comb begin
    logic [DW-1:0] r;
    logic [QW-1:0] d;
    logic [QW-1:0] q;
    logic [DW:0]   t;
    for (int s = 1; s <= NS; s++) begin
      r = rem_r[s-1];
      d = dvd_r[s-1];
      q = quo_r[s-1];
      for (int k = 0; k < pep_pkg::QPER; k++) begin
        t = {r, d[QW-1]};
        d = {d[QW-2:0], 1'b0};
        if (t >= {1'b0, dep_r[s-1]}) begin
          t = t - {1'b0, dep_r[s-1]};
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = t[DW-1:0];
      end
      rem_nxt[s] = r;
      dvd_nxt[s] = d;
      quo_nxt[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= hi_w;
      dvd_r[0]  <= prod_i[QW-1:0];
      quo_r[0]  <= '0;
      dep_r[0]  <= depth_i;
      cap_r[0]  <= (depth_i == '0) || (hi_w >= depth_i);
      zero_r[0] <= (prod_i == '0);
      for (int s = 1; s <= NS; s++) begin
        rem_r[s]  <= rem_nxt[s];
        dvd_r[s]  <= dvd_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        dep_r[s]  <= dep_r[s-1];
        cap_r[s]  <= cap_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
    end
  end

  assign q_o    = quo_r[NS];
  assign cap_o  = cap_r[NS];
  assign zero_o = zero_r[NS];

endmodule

/* rtl/pep_sdiv.sv */
module pep_sdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pep_pkg::SMAG_W-1:0]    mag_i,
  input  logic [pep_pkg::SPAN_W-1:0]    span_i,
  output logic [pep_pkg::SMAG_W-1:0]    q_o
);

  localparam int MW = pep_pkg::SMAG_W;
  localparam int SW = pep_pkg::SPAN_W;
  localparam int NS = pep_pkg::SSTG;

  logic [SW-1:0] rem_r [0:NS-1];
  logic [MW-1:0] dvd_r [0:NS-1];
  logic [MW-1:0] quo_r [0:NS-1];
  logic [SW-1:0] spn_r [0:NS-1];

  logic [SW-1:0] rem_nxt [0:NS-1];
  logic [MW-1:0] dvd_nxt [0:NS-1];
  logic [MW-1:0] quo_nxt [0:NS-1];
  logic [SW-1:0] spn_nxt [0:NS-1];

  always_comb begin
    logic [SW-1:0] r;
    logic [MW-1:0] d;
    logic [MW-1:0] q;
    logic [SW-1:0] dv;
    logic [SW:0]   t;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        r  = '0;
        d  = mag_i;
        q  = '0;
        dv = span_i;
      end else begin
        r  = rem_r[s-1];
        d  = dvd_r[s-1];
        q  = quo_r[s-1];
        dv = spn_r[s-1];
      end
      for (int k = 0; k < pep_pkg::SPER; k++) begin
        t = {r, d[MW-1]};
        d = {d[MW-2:0], 1'b0};
        if (t >= {1'b0, dv}) begin
          t = t - {1'b0, dv};
          q = {q[MW-2:0], 1'b1};
        end else begin
          q = {q[MW-2:0], 1'b0};
        end
        r = t[SW-1:0];
      end
      rem_nxt[s] = r;
      dvd_nxt[s] = d;
      quo_nxt[s] = q;
      spn_nxt[s] = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        dvd_r[s] <= dvd_nxt[s];
        quo_r[s] <= quo_nxt[s];
        spn_r[s] <= spn_nxt[s];
      end
    end
  end

  assign q_o = quo_r[NS-1];

endmodule

/* rtl/portal_edge_projection.sv */
// portal opening edge projector
// input channel: in_valid / in_stall carry one portal wall item (columns,
// endpoint depths, sector and neighbor floor and ceiling heights)
// result channel: out_valid / out_stall carry one item per input item with
// the projected top and bottom edge Y at both ends, per-column slopes and
// the pixel rows of both edges
// cfg port: cfg_write_en with cfg_index and cfg_data writes focal_scale,
// screen_center_y or eye_height; write only while no item is in flight
// latency: 38 register stages, so an item accepted at one edge can be taken
// at the 38th edge after it: four front stages, 18 in the projection divider
// (an input register and 17 stages of two quotient bits), four between the
// dividers, 11 in the slope divider (three quotient bits per stage) and the
// output register
// throughput: one item per cycle while out_stall is low
// stall: the whole pipeline freezes when the output register holds an item
// that is not taken; in_stall rises in the same cycle, so no item is lost
// reset: rst_n low clears all valid bits and loads the register defaults
module portal_edge_projection (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_write_en,
  input  logic [1:0]                       cfg_index,
  input  logic [pep_pkg::DATA_W-1:0]       cfg_data,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_left_column,
  input  logic signed [15:0]               in_right_column,
  input  logic [31:0]                      in_left_depth,
  input  logic [31:0]                      in_right_depth,
  input  logic signed [31:0]               in_sector_floor,
  input  logic signed [31:0]               in_sector_ceiling,
  input  logic signed [31:0]               in_neighbor_floor,
  input  logic signed [31:0]               in_neighbor_ceiling,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_left_column,
  output logic signed [15:0]               out_right_column,
  output logic signed [31:0]               out_ceil_y_left,
  output logic signed [31:0]               out_ceil_y_right,
  output logic signed [31:0]               out_floor_y_left,
  output logic signed [31:0]               out_floor_y_right,
  output logic signed [31:0]               out_ceil_slope,
  output logic signed [31:0]               out_floor_slope,
  output logic signed [15:0]               out_ceil_row_left,
  output logic signed [15:0]               out_ceil_row_right,
  output logic signed [15:0]               out_floor_row_left,
  output logic signed [15:0]               out_floor_row_right
);

  localparam int DW = pep_pkg::DATA_W;
  localparam int CW = pep_pkg::COL_W;
  localparam int QW = pep_pkg::QUOT_W;
  localparam int PW = pep_pkg::PROD_W;
  localparam int MW = pep_pkg::SMAG_W;
  localparam int FB = pep_pkg::FRAC_BITS;
  localparam int NQ = pep_pkg::QSTG;
  localparam int NS = pep_pkg::SSTG;

  // configuration registers
  logic [DW-1:0] focal_r;
  logic [DW-1:0] center_r;
  logic [DW-1:0] eye_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= pep_pkg::FOCAL_RESET;
      center_r <= pep_pkg::CENTER_RESET;
      eye_r    <= pep_pkg::EYE_RESET;
    end else if (cfg_write_en) begin
      case (pep_pkg::pep_cfg_idx_t'(cfg_index))
        pep_pkg::CFG_FOCAL_SCALE:     focal_r  <= cfg_data;
        pep_pkg::CFG_SCREEN_CENTER_Y: center_r <= cfg_data;
        pep_pkg::CFG_EYE_HEIGHT:      eye_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output item is held
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage a: opening pick and column span
  logic          a_valid_r;
  logic [CW-1:0] a_lc_r, a_rc_r;
  logic [DW-1:0] a_zl_r, a_zr_r, a_vc_r, a_vf_r;
  logic          a_span_pos_r;
  logic [CW-1:0] a_span_r;
  logic [CW:0]   span_w;
  assign span_w = {in_right_column[CW-1], in_right_column}
                - {in_left_column[CW-1], in_left_column};

  // stage b: heights relative to the eye
  logic          b_valid_r;
  logic [CW-1:0] b_lc_r, b_rc_r, b_span_r;
  logic          b_span_pos_r;
  logic [DW-1:0] b_zl_r, b_zr_r;
  logic [DW:0]   b_hc_r, b_hf_r;

  // stage c: magnitudes
  logic          c_valid_r;
  logic [CW-1:0] c_lc_r, c_rc_r, c_span_r;
  logic          c_span_pos_r;
  logic [DW-1:0] c_zl_r, c_zr_r;
  logic [DW:0]   c_magc_r, c_magf_r;
  logic          c_negc_r, c_negf_r;

  // stage d: products
  pep_pkg::pep_qside_t d_side_r;
  logic [DW-1:0] d_zl_r, d_zr_r;
  logic [PW-1:0] d_prodc_r, d_prodf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_side_r  <= '0;
    end else if (en) begin
      a_valid_r         <= in_valid;
      b_valid_r         <= a_valid_r;
      c_valid_r         <= b_valid_r;
      d_side_r.valid    <= c_valid_r;
      d_side_r.lc       <= c_lc_r;
      d_side_r.rc       <= c_rc_r;
      d_side_r.negc     <= c_negc_r;
      d_side_r.negf     <= c_negf_r;
      d_side_r.span_pos <= c_span_pos_r;
      d_side_r.span     <= c_span_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lc_r       <= in_left_column;
      a_rc_r       <= in_right_column;
      a_zl_r       <= in_left_depth;
      a_zr_r       <= in_right_depth;
      a_vc_r       <= (in_sector_ceiling > in_neighbor_ceiling) ? in_sector_ceiling
                                                                 : in_neighbor_ceiling;
      a_vf_r       <= (in_sector_floor < in_neighbor_floor) ? in_sector_floor
                                                             : in_neighbor_floor;
      a_span_pos_r <= !span_w[CW] && (span_w != '0);
      a_span_r     <= span_w[CW-1:0];

      b_lc_r       <= a_lc_r;
      b_rc_r       <= a_rc_r;
      b_span_r     <= a_span_r;
      b_span_pos_r <= a_span_pos_r;
      b_zl_r       <= a_zl_r;
      b_zr_r       <= a_zr_r;
      b_hc_r       <= {a_vc_r[DW-1], a_vc_r} - {eye_r[DW-1], eye_r};
      b_hf_r       <= {a_vf_r[DW-1], a_vf_r} - {eye_r[DW-1], eye_r};

      c_lc_r       <= b_lc_r;
      c_rc_r       <= b_rc_r;
      c_span_r     <= b_span_r;
      c_span_pos_r <= b_span_pos_r;
      c_zl_r       <= b_zl_r;
      c_zr_r       <= b_zr_r;
      c_negc_r     <= b_hc_r[DW];
      c_negf_r     <= b_hf_r[DW];
      c_magc_r     <= b_hc_r[DW] ? (~b_hc_r + 1'b1) : b_hc_r;
      c_magf_r     <= b_hf_r[DW] ? (~b_hf_r + 1'b1) : b_hf_r;

      d_zl_r            <= c_zl_r;
      d_zr_r            <= c_zr_r;
      // a magnitude of exactly 2^32 has all low bits clear
      d_prodc_r <= c_magc_r[DW] ? {focal_r, {DW{1'b0}}}
                                : (PW'(c_magc_r[DW-1:0]) * PW'(focal_r));
      d_prodf_r <= c_magf_r[DW] ? {focal_r, {DW{1'b0}}}
                                : (PW'(c_magf_r[DW-1:0]) * PW'(focal_r));
    end
  end

  // projection dividers, one for each edge end
  logic [QW-1:0] q_cl, q_cr, q_fl, q_fr;
  logic          cap_cl, cap_cr, cap_fl, cap_fr;
  logic          zero_cl, zero_cr, zero_fl, zero_fr;

  pep_qdiv u_qdiv_cl (.clk(clk), .en(en), .prod_i(d_prodc_r), .depth_i(d_zl_r),
                      .q_o(q_cl), .cap_o(cap_cl), .zero_o(zero_cl));
  pep_qdiv u_qdiv_cr (.clk(clk), .en(en), .prod_i(d_prodc_r), .depth_i(d_zr_r),
                      .q_o(q_cr), .cap_o(cap_cr), .zero_o(zero_cr));
  pep_qdiv u_qdiv_fl (.clk(clk), .en(en), .prod_i(d_prodf_r), .depth_i(d_zl_r),
                      .q_o(q_fl), .cap_o(cap_fl), .zero_o(zero_fl));
  pep_qdiv u_qdiv_fr (.clk(clk), .en(en), .prod_i(d_prodf_r), .depth_i(d_zr_r),
                      .q_o(q_fr), .cap_o(cap_fr), .zero_o(zero_fr));

  pep_pkg::pep_qside_t qd_side_r [0:NQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NQ; s++) begin
        qd_side_r[s] <= '0;
      end
    end else if (en) begin
      qd_side_r[0] <= d_side_r;
      for (int s = 1; s <= NQ; s++) begin
        qd_side_r[s] <= qd_side_r[s-1];
      end
    end
  end

  // zero product wins over a zero depth, then the cap
  function automatic logic signed [QW:0] signed_quot(
    input logic [QW-1:0] q, input logic cap, input logic zero, input logic neg);
    logic [QW-1:0] qf;
    if (zero) begin
      qf = '0;
    end else if (cap || (q > pep_pkg::QUOT_CAP)) begin
      qf = pep_pkg::QUOT_CAP;
    end else begin
      qf = q;
    end
    return neg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
  endfunction

  // stage e1: signed quotients
  pep_pkg::pep_qside_t e1_side_r;
  logic signed [QW:0] e1_cl_r, e1_cr_r, e1_fl_r, e1_fr_r;

  // stage e2: screen Y
  pep_pkg::pep_qside_t e2_side_r;
  logic [DW-1:0] e2_cl_r, e2_cr_r, e2_fl_r, e2_fr_r;

  // stage f1: rows and edge deltas
  pep_pkg::pep_sside_t f1_side_r;
  logic [CW-1:0] f1_span_r;
  logic [DW:0]   f1_dc_r, f1_df_r;

  // stage f2: delta magnitudes
  pep_pkg::pep_sside_t f2_side_r;
  logic [CW-1:0] f2_span_r;
  logic [MW-1:0] f2_magc_r, f2_magf_r;

  logic signed [35:0] center_x;
  assign center_x = 36'(signed'(center_r));

  function automatic logic [CW-1:0] row_down(input logic [DW-1:0] y);
    logic signed [DW:0] v;
    v = $signed({y[DW-1], y}) >>> FB;
    return pep_pkg::sat_s16(v);
  endfunction

  function automatic logic [CW-1:0] row_up(input logic [DW-1:0] y);
    logic signed [DW:0] v;
    v = ($signed({y[DW-1], y}) + $signed((DW+1)'((1 << FB) - 1))) >>> FB;
    return pep_pkg::sat_s16(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_side_r <= '0;
      e2_side_r <= '0;
      f1_side_r <= '0;
      f2_side_r <= '0;
    end else if (en) begin
      e1_side_r <= qd_side_r[NQ];
      e2_side_r <= e1_side_r;

      f1_side_r.valid    <= e2_side_r.valid;
      f1_side_r.lc       <= e2_side_r.lc;
      f1_side_r.rc       <= e2_side_r.rc;
      f1_side_r.span_pos <= e2_side_r.span_pos;
      f1_side_r.cyl      <= e2_cl_r;
      f1_side_r.cyr      <= e2_cr_r;
      f1_side_r.fyl      <= e2_fl_r;
      f1_side_r.fyr      <= e2_fr_r;
      f1_side_r.crl      <= row_down(e2_cl_r);
      f1_side_r.crr      <= row_down(e2_cr_r);
      f1_side_r.frl      <= row_up(e2_fl_r);
      f1_side_r.frr      <= row_up(e2_fr_r);
      // slope signs: right end above the left end
      f1_side_r.negc     <= $signed(e2_cr_r) < $signed(e2_cl_r);
      f1_side_r.negf     <= $signed(e2_fr_r) < $signed(e2_fl_r);

      f2_side_r <= f1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_cl_r <= signed_quot(q_cl, cap_cl, zero_cl, qd_side_r[NQ].negc);
      e1_cr_r <= signed_quot(q_cr, cap_cr, zero_cr, qd_side_r[NQ].negc);
      e1_fl_r <= signed_quot(q_fl, cap_fl, zero_fl, qd_side_r[NQ].negf);
      e1_fr_r <= signed_quot(q_fr, cap_fr, zero_fr, qd_side_r[NQ].negf);

      e2_cl_r <= pep_pkg::sat_s32(36'(e1_cl_r) + center_x);
      e2_cr_r <= pep_pkg::sat_s32(36'(e1_cr_r) + center_x);
      e2_fl_r <= pep_pkg::sat_s32(36'(e1_fl_r) + center_x);
      e2_fr_r <= pep_pkg::sat_s32(36'(e1_fr_r) + center_x);

      f1_span_r <= e2_side_r.span;
      f1_dc_r   <= {e2_cr_r[DW-1], e2_cr_r} - {e2_cl_r[DW-1], e2_cl_r};
      f1_df_r   <= {e2_fr_r[DW-1], e2_fr_r} - {e2_fl_r[DW-1], e2_fl_r};

      f2_span_r <= f1_span_r;
      f2_magc_r <= f1_dc_r[DW] ? (~f1_dc_r + 1'b1) : f1_dc_r;
      f2_magf_r <= f1_df_r[DW] ? (~f1_df_r + 1'b1) : f1_df_r;
    end
  end

  // slope dividers
  logic [MW-1:0] sq_c, sq_f;

  pep_sdiv u_sdiv_c (.clk(clk), .en(en), .mag_i(f2_magc_r), .span_i(f2_span_r),
                     .q_o(sq_c));
  pep_sdiv u_sdiv_f (.clk(clk), .en(en), .mag_i(f2_magf_r), .span_i(f2_span_r),
                     .q_o(sq_f));

  pep_pkg::pep_sside_t sd_side_r [0:NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        sd_side_r[s] <= '0;
      end
    end else if (en) begin
      sd_side_r[0] <= f2_side_r;
      for (int s = 1; s < NS; s++) begin
        sd_side_r[s] <= sd_side_r[s-1];
      end
    end
  end

  function automatic logic [DW-1:0] slope_out(
    input logic [MW-1:0] q, input logic neg, input logic pos);
    logic signed [MW:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return pos ? pep_pkg::sat_s32(36'(v)) : '0;
  endfunction

  // output register
  pep_pkg::pep_sside_t o_side;
  logic [DW-1:0] o_cs_r, o_fs_r;
  logic [CW-1:0] o_lc_r, o_rc_r, o_crl_r, o_crr_r, o_frl_r, o_frr_r;
  logic [DW-1:0] o_cyl_r, o_cyr_r, o_fyl_r, o_fyr_r;

  assign o_side = sd_side_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= o_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_lc_r  <= o_side.lc;
      o_rc_r  <= o_side.rc;
      o_cyl_r <= o_side.cyl;
      o_cyr_r <= o_side.cyr;
      o_fyl_r <= o_side.fyl;
      o_fyr_r <= o_side.fyr;
      o_crl_r <= o_side.crl;
      o_crr_r <= o_side.crr;
      o_frl_r <= o_side.frl;
      o_frr_r <= o_side.frr;
      o_cs_r  <= slope_out(sq_c, o_side.negc, o_side.span_pos);
      o_fs_r  <= slope_out(sq_f, o_side.negf, o_side.span_pos);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_column     = o_lc_r;
  assign out_right_column    = o_rc_r;
  assign out_ceil_y_left     = o_cyl_r;
  assign out_ceil_y_right    = o_cyr_r;
  assign out_floor_y_left    = o_fyl_r;
  assign out_floor_y_right   = o_fyr_r;
  assign out_ceil_slope      = o_cs_r;
  assign out_floor_slope     = o_fs_r;
  assign out_ceil_row_left   = o_crl_r;
  assign out_ceil_row_right  = o_crr_r;
  assign out_floor_row_left  = o_frl_r;
  assign out_floor_row_right = o_frr_r;

`ifndef ASSERT_OFF
  // a held output freezes the valid bits of the whole pipeline
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(a_valid_r) && $stable(e1_side_r.valid)
                 && $stable(sd_side_r[NS-1].valid) && $stable(out_valid_r))
    else $error("pipeline moved while stalled");

  // no positive span means flat edges
  a_flat_slope: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_right_column <= out_left_column)
    |-> (out_ceil_slope == '0) && (out_floor_slope == '0))
    else $error("slope not zero for empty span");

  // floored top row never passes the ceiled bottom row of a lower edge
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_ceil_y_left <= out_floor_y_left)
    |-> (out_ceil_row_left <= out_floor_row_left))
    else $error("row order broken");
`endif

endmodule
